>>> rtl/ac_pkg.sv
// Shared types, constants and fixed-point helpers for the admittance controller.
// Used by ac_mul and admittance_controller; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ac_pkg;

	// Field widths of the streams and the registers.
	localparam int TORQUE_W = 24;
	localparam int TIME_W   = 20;
	localparam int DT_W     = 17;
	localparam int GAIN_W   = 24;
	localparam int LIMIT_W  = 23;
	localparam int ALPHA_W  = 17;
	localparam int IMASS_W  = 32;
	localparam int ACCEL_W  = 32;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 3;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	// Shared multiplier: signed A_W x signed B_W into PROD_W bits.
	localparam int A_W    = 33;
	localparam int B_W    = 25;
	localparam int PROD_W = A_W + B_W;
	localparam int ACC_W  = 42;

	// Fixed constants of the control law.
	localparam int TORQUE_BIAS    = 0;
	localparam int NOMINAL_PERIOD = 5243;
	localparam int DT_MAX         = 104858;
	localparam int ALPHA_ONE      = 65536;

	// Register indexes on the configuration port.
	localparam logic [IDX_W-1:0] REG_INVERSE_MASS  = 3'd0;
	localparam logic [IDX_W-1:0] REG_DAMPING       = 3'd1;
	localparam logic [IDX_W-1:0] REG_STIFFNESS     = 3'd2;
	localparam logic [IDX_W-1:0] REG_DISP_LIMIT    = 3'd3;
	localparam logic [IDX_W-1:0] REG_VEL_LIMIT     = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEADBAND      = 3'd5;
	localparam logic [IDX_W-1:0] REG_ALPHA         = 3'd6;
	localparam logic [IDX_W-1:0] REG_NEUTRAL       = 3'd7;

	// Register reset values.
	localparam logic [IMASS_W-1:0]  RST_INVERSE_MASS = 32'd1310720;
	localparam logic [GAIN_W-1:0]   RST_DAMPING      = 24'd26214;
	localparam logic [GAIN_W-1:0]   RST_STIFFNESS    = 24'd98304;
	localparam logic [LIMIT_W-1:0]  RST_DISP_LIMIT   = 23'd39322;
	localparam logic [LIMIT_W-1:0]  RST_VEL_LIMIT    = 23'd262144;
	localparam logic [LIMIT_W-1:0]  RST_DEADBAND     = 23'd1311;
	localparam logic [ALPHA_W-1:0]  RST_ALPHA        = 17'd65536;

	// Saturation bounds at product width.
	localparam logic signed [PROD_W-1:0] S24_MAX_W = PROD_W'(8388607);
	localparam logic signed [PROD_W-1:0] S24_MIN_W = -PROD_W'(8388608);
	localparam logic signed [PROD_W-1:0] S32_MAX_W = PROD_W'(2147483647);
	localparam logic signed [PROD_W-1:0] S32_MIN_W = -S32_MAX_W - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] HALF16_W  = PROD_W'(32768);
	localparam logic signed [PROD_W-1:0] HALF20_W  = PROD_W'(524288);

	// Sequencer states: idle, one per multiply issue or result step, and the output load.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_F1,
		ST_F2,
		ST_FS,
		ST_D,
		ST_K,
		ST_KS,
		ST_M,
		ST_MS,
		ST_V,
		ST_VS,
		ST_X,
		ST_XS,
		ST_OUT
	} state_t;

	// Operands handed to the shared multiplier.
	typedef struct packed {
		logic signed [A_W-1:0] a;
		logic signed [B_W-1:0] b;
	} mul_op_t;

	// Rescale by 2^-16 with rounding half up.
	function automatic logic signed [PROD_W-1:0] rsh16(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + HALF16_W;
		return t >>> 16;
	endfunction

	// Rescale by 2^-20 with rounding half up.
	function automatic logic signed [PROD_W-1:0] rsh20(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + HALF20_W;
		return t >>> 20;
	endfunction

	// Saturate to 24 bit signed.
	function automatic logic signed [23:0] sat24(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v;
		if (t > S24_MAX_W)
			t = S24_MAX_W;
		else if (t < S24_MIN_W)
			t = S24_MIN_W;
		return t[23:0];
	endfunction

	// Saturate to 32 bit signed.
	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v;
		if (t > S32_MAX_W)
			t = S32_MAX_W;
		else if (t < S32_MIN_W)
			t = S32_MIN_W;
		return t[31:0];
	endfunction

	// Symmetric clamp to +-lim; a zero limit leaves the value alone.
	function automatic logic signed [23:0] clamp24(input logic signed [23:0] v,
			input logic [LIMIT_W-1:0] lim);
		logic signed [23:0] l;
		logic signed [23:0] r;
		l = $signed({1'b0, lim});
		r = v;
		if (lim != '0) begin
			if (v > l)
				r = l;
			else if (v < -l)
				r = -l;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ac_mul.sv
// Shared signed multiplier of the admittance controller with a registered product.
// Depends on ac_pkg for operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module ac_mul (
	input  wire logic                           clk,
	input  wire ac_pkg::mul_op_t                op,
	output logic signed [ac_pkg::PROD_W-1:0]    prod_q
);
	import ac_pkg::*;

	// One product per cycle; the sequencer picks it up on the next cycle.
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op.a) * PROD_W'(op.b);
	end

endmodule

`default_nettype wire

>>> rtl/admittance_controller.sv
// Admittance controller: sequencer, state and configuration around one shared multiplier.
// Depends on ac_pkg and instantiates ac_mul.
//
// Usage: each item on the slave stream is one control tick. tdata carries the measured
// torque and the elapsed time, tuser the status-valid and fault flags. A tick that is
// accepted while the block is halted, or with status-valid low and no fault, gives no
// result. A fault gives one result with stop_request set and halts the block until reset.
// Any other tick gives one position reference on the master stream.
// The block takes one item at a time: s_tready is high only while the sequencer is idle.
// A normal tick steps through the states F1, F2, FS, D, K, KS, M, MS, V, VS, X, XS and OUT
// before the next item can be accepted; the first tick, which seeds the torque filter,
// starts at D. The steps are set by the seven products that go in turn through the
// single multiplier: the two filter products and the two damping and spring products each
// share a rescale state, the other three products each get their own, and a last state
// loads the output register, from which the result is offered on the master stream.
// A fault tick goes from acceptance straight to that last state, which loads its result.
// The result sits in an output register, so a stall on the master side holds only the
// finished item; the sequencer then waits in its last step until the register is free.
// Reset clears the filter, the integrator state, the halt flag and sets every register
// to its default. Configuration is written through cfg_we, cfg_index and cfg_data.
`timescale 1ns / 1ps
`default_nettype none

module admittance_controller (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration writes.
	input  wire logic                              cfg_we,
	input  wire logic [ac_pkg::IDX_W-1:0]          cfg_index,
	input  wire logic [ac_pkg::CFG_W-1:0]          cfg_data,
	// Tick stream in.
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// measured_torque [23:0], elapsed_time [43:24], zero [47:44]
	input  wire logic [ac_pkg::IN_TDATA_W-1:0]     s_tdata,
	// status_valid [0], fault_seen [1]
	input  wire logic [1:0]                        s_tuser,
	// Result stream out.
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// commanded position [23:0]
	output logic [ac_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// stop_request [0]
	output logic                                   m_tuser
);
	import ac_pkg::*;

	// Configuration registers.
	logic [IMASS_W-1:0]         inv_mass_q;
	logic [GAIN_W-1:0]          damping_q;
	logic [GAIN_W-1:0]          stiffness_q;
	logic [LIMIT_W-1:0]         disp_limit_q;
	logic [LIMIT_W-1:0]         vel_limit_q;
	logic [LIMIT_W-1:0]         deadband_q;
	logic [ALPHA_W-1:0]         alpha_q;
	logic signed [23:0]         neutral_q;

	// Controller state.
	state_t                     state_q, state_d;
	logic                       halted_q;
	logic                       primed_q;
	logic                       stop_pend_q;
	logic signed [23:0]         filt_q;
	logic signed [23:0]         vel_q;
	logic signed [23:0]         disp_q;

	// Per-item working registers.
	logic signed [23:0]         torque_q;
	logic [DT_W-1:0]            dt_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [23:0]         net_q;
	logic signed [ACCEL_W-1:0]  accel_q;

	// Output register.
	logic                       out_valid_q;
	logic signed [23:0]         out_pos_q;
	logic                       out_stop_q;

	// Multiplier.
	mul_op_t                    mul_op;
	logic signed [PROD_W-1:0]   prod_q;

	logic                       in_accept;
	logic                       out_free;
	logic                       out_load;

	ac_mul u_mul (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod_q)
	);

	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign out_load  = (state_q == ST_OUT) && out_free;

	// Input conditioning: bias removal, saturation, deadband and time-step clamp, with a nominal step for zero time.
	logic signed [23:0]         tq_in;
	logic signed [24:0]         tq_unbiased;
	logic signed [23:0]         tq_sat;
	logic [23:0]                tq_abs;
	logic signed [23:0]         tq_clean;
	logic [TIME_W-1:0]          et_in;
	logic [DT_W-1:0]            dt_in;

	always_comb begin
		tq_in       = $signed(s_tdata[23:0]);
		tq_unbiased = $signed({tq_in[23], tq_in}) - 25'(TORQUE_BIAS);
		if (tq_unbiased > 25'sd8388607)
			tq_sat = 24'sh7FFFFF;
		else if (tq_unbiased < -25'sd8388608)
			tq_sat = 24'sh800000;
		else
			tq_sat = tq_unbiased[23:0];
		tq_abs   = tq_sat[23] ? 24'(-tq_sat) : tq_sat;
		tq_clean = (tq_abs < {1'b0, deadband_q}) ? '0 : tq_sat;

		et_in = s_tdata[43:24];
		if (et_in > TIME_W'(DT_MAX))
			dt_in = DT_W'(DT_MAX);
		else if (et_in == '0)
			dt_in = DT_W'(NOMINAL_PERIOD);
		else
			dt_in = et_in[DT_W-1:0];
	end

	// Result arithmetic on the registered product, and the position sum.
	logic [ALPHA_W-1:0]         alpha_eff;
	logic [ALPHA_W-1:0]         alpha_rest;
	logic signed [PROD_W-1:0]   acc_ext;
	logic signed [PROD_W-1:0]   filt_ext;
	logic signed [PROD_W-1:0]   vel_ext;
	logic signed [PROD_W-1:0]   disp_ext;
	logic signed [PROD_W-1:0]   sum_w;
	logic signed [23:0]         filt_new;
	logic signed [PROD_W-1:0]   net_part;
	logic signed [23:0]         net_new;
	logic signed [ACCEL_W-1:0]  accel_new;
	logic signed [23:0]         vel_new;
	logic signed [23:0]         disp_new;
	logic signed [24:0]         pos_sum;
	logic signed [23:0]         pos_new;

	always_comb begin
		alpha_eff  = (alpha_q > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_q;
		alpha_rest = ALPHA_W'(ALPHA_ONE) - alpha_eff;

		acc_ext  = {{(PROD_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
		filt_ext = {{(PROD_W-24){filt_q[23]}}, filt_q};
		vel_ext  = {{(PROD_W-24){vel_q[23]}}, vel_q};
		disp_ext = {{(PROD_W-24){disp_q[23]}}, disp_q};

		sum_w    = acc_ext + prod_q;
		filt_new = sat24(rsh16(sum_w));

		net_part  = filt_ext - rsh16(prod_q);
		net_new   = sat24(acc_ext - rsh16(prod_q));
		accel_new = sat32(rsh16(prod_q));
		vel_new   = clamp24(sat24(vel_ext + rsh20(prod_q)), vel_limit_q);
		disp_new  = clamp24(sat24(disp_ext + rsh20(prod_q)), disp_limit_q);

		pos_sum = $signed({neutral_q[23], neutral_q}) + $signed({disp_q[23], disp_q});
		if (pos_sum > 25'sd8388607)
			pos_new = 24'sh7FFFFF;
		else if (pos_sum < -25'sd8388608)
			pos_new = 24'sh800000;
		else
			pos_new = pos_sum[23:0];
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, ready and multiplier operands.
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		mul_op   = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (halted_q)
						state_d = ST_IDLE;
					else if (s_tuser[1])
						state_d = ST_OUT;
					else if (!s_tuser[0])
						state_d = ST_IDLE;
					else if (!primed_q)
						state_d = ST_D;
					else
						state_d = ST_F1;
				end
			end
			ST_F1: begin
				mul_op.a = $signed(A_W'(alpha_eff));
				mul_op.b = B_W'(torque_q);
				state_d  = ST_F2;
			end
			ST_F2: begin
				mul_op.a = $signed(A_W'(alpha_rest));
				mul_op.b = B_W'(filt_q);
				state_d  = ST_FS;
			end
			ST_FS: begin
				state_d = ST_D;
			end
			ST_D: begin
				mul_op.a = $signed(A_W'(damping_q));
				mul_op.b = B_W'(vel_q);
				state_d  = ST_K;
			end
			ST_K: begin
				mul_op.a = $signed(A_W'(stiffness_q));
				mul_op.b = B_W'(disp_q);
				state_d  = ST_KS;
			end
			ST_KS: begin
				state_d = ST_M;
			end
			ST_M: begin
				mul_op.a = $signed(A_W'(inv_mass_q));
				mul_op.b = B_W'(net_q);
				state_d  = ST_MS;
			end
			ST_MS: begin
				state_d = ST_V;
			end
			ST_V: begin
				mul_op.a = A_W'(accel_q);
				mul_op.b = $signed(B_W'(dt_q));
				state_d  = ST_VS;
			end
			ST_VS: begin
				state_d = ST_X;
			end
			ST_X: begin
				mul_op.a = A_W'(vel_q);
				mul_op.b = $signed(B_W'(dt_q));
				state_d  = ST_XS;
			end
			ST_XS: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q   <= RST_INVERSE_MASS;
			damping_q    <= RST_DAMPING;
			stiffness_q  <= RST_STIFFNESS;
			disp_limit_q <= RST_DISP_LIMIT;
			vel_limit_q  <= RST_VEL_LIMIT;
			deadband_q   <= RST_DEADBAND;
			alpha_q      <= RST_ALPHA;
			neutral_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INVERSE_MASS: inv_mass_q   <= cfg_data[IMASS_W-1:0];
				REG_DAMPING:      damping_q    <= cfg_data[GAIN_W-1:0];
				REG_STIFFNESS:    stiffness_q  <= cfg_data[GAIN_W-1:0];
				REG_DISP_LIMIT:   disp_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_VEL_LIMIT:    vel_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_DEADBAND:     deadband_q   <= cfg_data[LIMIT_W-1:0];
				REG_ALPHA:        alpha_q      <= cfg_data[ALPHA_W-1:0];
				REG_NEUTRAL:      neutral_q    <= $signed(cfg_data[23:0]);
				default: ;
			endcase
		end
	end

	// Filter, integrator and halt state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q    <= 1'b0;
			primed_q    <= 1'b0;
			stop_pend_q <= 1'b0;
			filt_q      <= '0;
			vel_q       <= '0;
			disp_q      <= '0;
		end else begin
			if (in_accept && !halted_q) begin
				stop_pend_q <= s_tuser[1];
				if (s_tuser[1]) begin
					halted_q <= 1'b1;
				end else if (s_tuser[0] && !primed_q) begin
					filt_q   <= tq_clean;
					primed_q <= 1'b1;
				end
			end
			if (state_q == ST_FS)
				filt_q <= filt_new;
			if (state_q == ST_VS)
				vel_q <= vel_new;
			if (state_q == ST_XS)
				disp_q <= disp_new;
		end
	end

	// Working registers of the item in flight.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			torque_q <= tq_clean;
			dt_q     <= dt_in;
		end
		if (state_q == ST_F2)
			acc_q <= ACC_W'(prod_q);
		else if (state_q == ST_K)
			acc_q <= ACC_W'(net_part);
		if (state_q == ST_KS)
			net_q <= net_new;
		if (state_q == ST_MS)
			accel_q <= accel_new;
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q  <= stop_pend_q ? '0 : pos_new;
			out_stop_q <= stop_pend_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pos_q;
	assign m_tuser  = out_stop_q;

endmodule

`default_nettype wire

>>> rtl/ac_checker.sv
// Port-level checks for the admittance controller, bound to the top level.
// Depends only on the top-level port names.
`timescale 1ns / 1ps
`default_nettype none

module ac_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// A stop result carries a zero position.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 24'd0)
		else $error("stop result with nonzero position");

	// A tick without status and without fault leaves the block ready.
	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] && !s_tuser[1] |=> s_tready)
		else $error("block busy after a tick without status");

	// A new result appears only after the block has been busy with an item.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while the block was idle");

endmodule

bind admittance_controller ac_checker u_ac_checker (.*);

`default_nettype wire
